// ----- rtl/min_tracking_stack_assert.svh -----
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MTS_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("min_tracking_stack check failed");

// Next-cycle implication.
`define MTS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack check failed");

`endif

// ----- rtl/mts_pkg.sv -----
package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDMIN,
        S_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;  // capture input, read both stack tops
        logic exec;    // apply push or pop
        logic rdmin;   // read the new minimum top
        logic load;    // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- rtl/mts_ctrl.sv -----
module mts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  mts_pkg::t_status  i_status,
    output mts_pkg::t_cmd     o_cmd
);
    import mts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RDMIN;
            end
            S_RDMIN: begin
                o_cmd.rdmin = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold until the previous result has been taken
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mts_dpath.sv -----
module mts_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mts_pkg::t_cmd                 i_cmd,
    output mts_pkg::t_status              o_status,
    input  logic                          i_action,
    input  logic [mts_pkg::WORD_W-1:0]    i_push_value,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mts_pkg::WORD_W-1:0]    o_popped_value,
    output logic                          o_pop_valid,
    output logic [mts_pkg::WORD_W-1:0]    o_minimum,
    output logic                          o_minimum_valid,
    output logic                          o_overflow
);
    import mts_pkg::*;

    logic [WORD_W-1:0] value_mem   [0:STACK_DEPTH-1];
    logic [WORD_W-1:0] minimum_mem [0:STACK_DEPTH-1];

    logic                     r_action;
    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] r_vrd;
    logic signed [WORD_W-1:0] r_mrd;
    logic [COUNT_W-1:0]       r_vcount;
    logic [COUNT_W-1:0]       r_mcount;
    logic [WORD_W-1:0]        r_popped;
    logic                     r_pop_ok;
    logic                     r_over;
    logic                     r_out_valid;
    logic [WORD_W-1:0]        r_out_popped;
    logic                     r_out_pop_ok;
    logic [WORD_W-1:0]        r_out_min;
    logic                     r_out_min_ok;
    logic                     r_out_over;

    logic [COUNT_W-1:0] n_vcount;
    logic [COUNT_W-1:0] n_mcount;
    logic [COUNT_W-1:0] vtop_cnt;
    logic [COUNT_W-1:0] mtop_cnt;
    logic [ADDR_W-1:0]  vtop_addr;
    logic [ADDR_W-1:0]  mtop_addr;
    logic               v_we;
    logic               m_we;
    logic               full;
    logic               min_nonempty;

    assign vtop_cnt  = r_vcount - COUNT_W'(1);
    assign mtop_cnt  = r_mcount - COUNT_W'(1);
    // an empty stack wraps the address; that read is never used
    assign vtop_addr = vtop_cnt[ADDR_W-1:0];
    assign mtop_addr = mtop_cnt[ADDR_W-1:0];
    assign full      = (r_vcount == COUNT_W'(STACK_DEPTH));

    always_comb begin
        n_vcount = r_vcount;
        n_mcount = r_mcount;
        v_we     = 1'b0;
        m_we     = 1'b0;
        if (i_cmd.exec) begin
            if (r_action == ACT_PUSH) begin
                if (!full) begin
                    v_we     = 1'b1;
                    n_vcount = r_vcount + COUNT_W'(1);
                    // minimum count never exceeds value count, so no bound check
                    if (r_mcount == '0 || r_word <= r_mrd) begin
                        m_we     = 1'b1;
                        n_mcount = r_mcount + COUNT_W'(1);
                    end
                end
            end else if (r_vcount != '0) begin
                n_vcount = vtop_cnt;
                if (r_mcount != '0 && r_mrd == r_vrd) begin
                    n_mcount = mtop_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            value_mem[r_vcount[ADDR_W-1:0]] <= r_word;
        end
        if (i_cmd.accept) begin
            r_vrd <= value_mem[vtop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            minimum_mem[r_mcount[ADDR_W-1:0]] <= r_word;
        end
        if (i_cmd.accept || i_cmd.rdmin) begin
            r_mrd <= minimum_mem[mtop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_mcount <= '0;
        end else begin
            r_vcount <= n_vcount;
            r_mcount <= n_mcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_word   <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_over   <= (r_action == ACT_PUSH) && full;
            r_pop_ok <= (r_action == ACT_POP) && (r_vcount != '0);
            r_popped <= ((r_action == ACT_POP) && (r_vcount != '0)) ? r_vrd : '0;
        end
    end

    assign min_nonempty = (r_vcount != '0) && (r_mcount != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_popped <= r_popped;
            r_out_pop_ok <= r_pop_ok;
            r_out_min    <= min_nonempty ? r_mrd : '0;
            r_out_min_ok <= min_nonempty;
            r_out_over   <= r_over;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_popped_value    = r_out_popped;
    assign o_pop_valid       = r_out_pop_ok;
    assign o_minimum         = r_out_min;
    assign o_minimum_valid   = r_out_min_ok;
    assign o_overflow        = r_out_over;

endmodule

// ----- rtl/min_tracking_stack.sv -----
// After an input transfer the controller steps through EXEC, RDMIN and FIN; FIN loads the result,
// and waits while m_tready is held low with a result pending. Items go one at a time: top read,
// update, minimum-top read, output load, each a step of the controller around the single-port stack memories.
// The next input transfer is taken while a result still waits in the output register.
// Reset (i_rst_n low, synchronous): both stacks empty, controller idle, no result pending.
// Stack memories are not cleared; only entries below the counts are ever used.
module min_tracking_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [0:0]  s_tuser,   // [0] action (0 push, 1 pop)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] popped_value, [63:32] minimum
    output logic [2:0]  m_tuser    // [0] pop_valid, [1] minimum_valid, [2] overflow
);
    import mts_pkg::*;

    t_cmd    cmd;
    t_status status;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mts_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_action        (s_tuser[0]),
        .i_push_value    (s_tdata[WORD_W-1:0]),
        .o_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .o_popped_value  (m_tdata[WORD_W-1:0]),
        .o_pop_valid     (m_tuser[0]),
        .o_minimum       (m_tdata[2*WORD_W-1:WORD_W]),
        .o_minimum_valid (m_tuser[1]),
        .o_overflow      (m_tuser[2])
    );

endmodule

// ----- rtl/mts_checker.sv -----
`include "min_tracking_stack_assert.svh"

module mts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // stalled result holds
    `MTS_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one item in flight: no transfer right after a transfer
    `MTS_CHECK_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    `MTS_CHECK(a_popped_zero, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0)

    `MTS_CHECK(a_min_zero, m_tvalid && !m_tuser[1], m_tdata[63:32] == 32'd0)

    // a full stack is never empty, and a dropped push removes nothing
    `MTS_CHECK(a_overflow_flags, m_tvalid && m_tuser[2], m_tuser[1] && !m_tuser[0])

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

// ----- bench/min_tracking_stack_tb.sv -----
`timescale 1ns / 100ps

module min_tracking_stack_tb;
    import mts_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 20;

    // Shadow of both stacks; every input transfer yields one expected result.
    class min_stack_scoreboard;
        typedef struct packed {
            logic [31:0] popped;
            logic        pop_ok;
            logic [31:0] minimum;
            logic        min_ok;
            logic        overflow;
        } stack_result_t;

        logic [31:0]   words [STACK_DEPTH];
        logic [31:0]   mins  [STACK_DEPTH];
        int            word_cnt = 0;
        int            min_cnt  = 0;
        stack_result_t pending [$];
        int            fail_count = 0;

        function void note_transfer(logic act, logic [31:0] word);
            stack_result_t r;
            r = '0;
            if (act == ACT_PUSH) begin
                if (word_cnt >= STACK_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    words[word_cnt] = word;
                    word_cnt++;
                    if (min_cnt == 0 || $signed(word) <= $signed(mins[min_cnt - 1])) begin
                        if (min_cnt < STACK_DEPTH) begin
                            mins[min_cnt] = word;
                            min_cnt++;
                        end
                    end
                end
            end else if (word_cnt > 0) begin
                word_cnt--;
                r.popped = words[word_cnt];
                r.pop_ok = 1'b1;
                if (min_cnt > 0 && mins[min_cnt - 1] == r.popped)
                    min_cnt--;
            end
            if (word_cnt > 0 && min_cnt > 0) begin
                r.minimum = mins[min_cnt - 1];
                r.min_ok  = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
                fail_count++;
            end
        endfunction

        function void check_result(logic [63:0] data, logic [2:0] flags);
            stack_result_t e;
            if (pending.size() == 0) begin
                $error("result transfer with no expected result waiting");
                fail_count++;
                return;
            end
            e = pending.pop_front();
            compare_field("popped_value", e.popped, data[31:0]);
            compare_field("pop_valid", {31'd0, e.pop_ok}, {31'd0, flags[0]});
            compare_field("minimum", e.minimum, data[63:32]);
            compare_field("minimum_valid", {31'd0, e.min_ok}, {31'd0, flags[1]});
            compare_field("overflow", {31'd0, e.overflow}, {31'd0, flags[2]});
        endfunction

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] push_value
    logic [0:0]  s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] popped_value, [63:32] minimum
    logic [2:0]  m_tuser;   // [0] pop_valid, [1] minimum_valid, [2] overflow

    min_stack_scoreboard sb = new();

    int send_idle = 0;      // percent of cycles the sender holds back
    int rx_stall  = 0;      // percent of cycles the receiver stalls
    int hold_seq  = 0;      // bumped by the driver to ask for a long receiver hold
    int hold_seen = 0;
    int depth_est = 0;      // driver-side view of the stack depth
    int item_no   = 0;
    int idle_cycles = 0;

    min_tracking_stack dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // transfer monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_transfer(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("min_tracking_stack regression: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, or a long hold counted here when asked
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall);
            end
        end
    end

    task automatic set_idle_mode(int mode);
        case (mode)
            0: begin send_idle = 0;  rx_stall = 0;  end
            1: begin send_idle = 59; rx_stall = 0;  end
            2: begin send_idle = 0;  rx_stall = 59; end
            default: begin send_idle = 15; rx_stall = 15; end
        endcase
    endtask

    task automatic send_item(logic act, logic [31:0] word);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= act;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (act == ACT_PUSH && depth_est < STACK_DEPTH)
            depth_est++;
        else if (act == ACT_POP && depth_est > 0)
            depth_est--;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            // narrow range so equal words hit the minimum stack often
            4, 5: return 32'($signed($urandom_range(15)) - 8);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_item(int push_pct);
        if (item_no % 50 == 0)
            set_idle_mode((item_no / 50) % 4);
        item_no++;
        if ($urandom_range(99) < push_pct)
            send_item(ACT_PUSH, pick_word());
        else
            send_item(ACT_POP, $urandom());
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pops, extremes, equal minima, bit patterns
        set_idle_mode(0);
        send_item(ACT_POP, 32'hdead_beef);
        send_item(ACT_PUSH, 32'h7fff_ffff);
        send_item(ACT_PUSH, 32'h8000_0000);
        send_item(ACT_PUSH, 32'h8000_0000);
        send_item(ACT_PUSH, 32'd5);
        repeat (4) send_item(ACT_POP, 32'h0);
        send_item(ACT_POP, 32'hffff_ffff);
        send_item(ACT_PUSH, 32'hffff_ffff);
        send_item(ACT_PUSH, 32'h0);
        send_item(ACT_PUSH, 32'h1);
        send_item(ACT_PUSH, 32'hffff_ffff);
        send_item(ACT_PUSH, 32'hffff_fffe);
        repeat (6) send_item(ACT_POP, 32'h0);
        send_item(ACT_PUSH, 32'h5555_5555);
        send_item(ACT_PUSH, 32'haaaa_aaaa);
        repeat (2) send_item(ACT_POP, 32'h0);
        wait_results_drained();

        // fill to the top and push past it
        while (depth_est < STACK_DEPTH) random_item(90);
        repeat (4) random_item(100);
        wait_results_drained();

        // drain to empty and pop past it
        while (depth_est > 0) random_item(10);
        repeat (3) random_item(0);
        wait_results_drained();

        // mixed traffic, starting from an empty stack
        repeat (200) random_item(30 + 20 * $urandom_range(2));

        // long receiver hold while the sender keeps offering
        set_idle_mode(0);
        hold_seq <= hold_seq + 1;
        repeat (12) random_item(60);

        repeat (200) random_item(30 + 20 * $urandom_range(2));

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_count() != 0)
            $error("expected results left over: %0d", sb.pending_count());
        if (sb.fail_count == 0 && sb.pending_count() == 0) begin
            $display("min_tracking_stack regression: pass");
        end else begin
            $display("min_tracking_stack regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_dpath.sv
rtl/min_tracking_stack.sv
rtl/mts_checker.sv
bench/min_tracking_stack_tb.sv
